// ----- src/msd_pkg.sv -----
// Shared types, constants and codes of the motion score debounce detector.
`default_nettype none

package msd_pkg;

   // Field widths
   localparam int TIME_WIDTH  = 48;
   localparam int VAR_W       = 24;
   localparam int FEAT_W      = 16;
   localparam int NORM_W      = 17;
   localparam int WEIGHT_W    = 16;
   localparam int SCORE_W     = 24;
   localparam int SCORE_SHIFT = 12;
   localparam int CONF_W      = 17;
   localparam int RUN_W       = 8;
   localparam int HOLD_W      = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int FEAT_COUNT  = 5;

   // Shared datapath widths
   localparam int DIV_W  = 23;
   localparam int QUO_W  = 16;
   localparam int PROD_W = WEIGHT_W + NORM_W + 1;
   localparam int ACC_W  = SCORE_W + SCORE_SHIFT;

   // Feature ranges (Q8.8 / Q16.8 raw units)
   localparam logic [VAR_W-1:0] VAR_HI    = VAR_W'(204800);
   localparam logic [VAR_W-1:0] ENT_LO    = VAR_W'(1024);
   localparam logic [VAR_W-1:0] ENT_HI    = VAR_W'(1792);
   localparam logic [VAR_W-1:0] SPREAD_HI = VAR_W'(12800);
   localparam logic [VAR_W-1:0] GRAD_HI   = VAR_W'(10240);
   localparam logic signed [NORM_W-1:0] CORR_ONE = NORM_W'(16384);
   localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(65536);
   localparam logic [CONF_W-1:0] CONF_ONE = CONF_W'(65536);
   localparam logic [RUN_W-1:0]  RUN_MAX  = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEAT,
      ST_DIV,
      ST_DRAIN,
      ST_SCORE,
      ST_CONF,
      ST_CDIV,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      FEAT_VARIANCE    = 3'd0,
      FEAT_ENTROPY     = 3'd1,
      FEAT_SPREAD      = 3'd2,
      FEAT_CORRELATION = 3'd3,
      FEAT_GRADIENT    = 3'd4
   } feat_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_VARIANCE    = 3'd0,
      CSR_WEIGHT_ENTROPY     = 3'd1,
      CSR_WEIGHT_IQR         = 3'd2,
      CSR_WEIGHT_CORRELATION = 3'd3,
      CSR_WEIGHT_GRADIENT    = 3'd4,
      CSR_THRESHOLD          = 3'd5,
      CSR_DEBOUNCE_NEEDED    = 3'd6,
      CSR_HOLD_TIMEOUT       = 3'd7
   } csr_idx_type;

   // Divider command: quotient of (num << 16) / den, num < den
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quo;
   } div_rsp_type;

   // Multiply-accumulate command
   typedef struct packed {
      logic                clr;
      logic                issue;
      logic [WEIGHT_W-1:0] weight;
      logic [NORM_W-1:0]   operand;
   } mac_req_type;

   typedef struct packed {
      logic             busy;
      logic [ACC_W-1:0] acc;
   } mac_rsp_type;

endpackage

`default_nettype wire

// ----- src/msd_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module msd_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire msd_pkg::div_req_type req,
   output msd_pkg::div_rsp_type      rsp
);
   import msd_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_W:0]   rem_dbl;
   logic             fits;

   // One restoring step
   always_comb begin
      rem_dbl = {rem_ff, 1'b0};
      fits    = rem_dbl >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = req.num;
         den_in  = req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(rem_dbl - {1'b0, den_ff}) : rem_dbl[DIV_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

`default_nettype wire

// ----- src/msd_mac.sv -----
// Shared multiplier with registered product and score accumulator.
`default_nettype none

module msd_mac (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire msd_pkg::mac_req_type req,
   output msd_pkg::mac_rsp_type      rsp
);
   import msd_pkg::*;

   logic signed [NORM_W:0]   op_s;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     pv_ff;

   // Weight times normalized feature
   always_comb begin
      op_s    = $signed({1'b0, req.operand});
      prod_in = $signed(req.weight) * op_s;
      acc_in  = acc_ff + ACC_W'(prod_ff);
   end

   // Product-valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (req.clr) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= req.issue;
      end
   end

   // Product and accumulator
   always_ff @(posedge clock) begin
      if (req.issue) begin
         prod_ff <= prod_in;
      end
      if (req.clr) begin
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign rsp.busy = pv_ff;
   assign rsp.acc  = acc_ff;

endmodule

`default_nettype wire

// ----- src/motion_score_debounce_detector.sv -----
// Top level: sequencer, feature clamping, confidence and debounce state.
`default_nettype none

// Each input beat carries five features and a timestamp and produces one
// result beat with score, confidence, detect flag and run count. Features are
// handled one after another: a feature inside its range goes through the
// shared 16-step divider, a clamped one and correlation skip the divider, and
// the weighted product feeds a shared multiplier/accumulator. With a positive
// threshold and a score between zero and the threshold, the same divider
// computes confidence. The divider yields one quotient bit per cycle; req_stall
// stays high while an item is in flight and drops as the result loads.
// A finished result sits in the output register, and the next item's result
// waits until that beat is taken. csr_ready is always high; registers should
// be written only while no item is in flight.
module motion_score_debounce_detector (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [msd_pkg::VAR_W-1:0]         req_variance,
   input  wire logic [msd_pkg::FEAT_W-1:0]        req_entropy,
   input  wire logic [msd_pkg::FEAT_W-1:0]        req_spread,
   input  wire logic signed [msd_pkg::FEAT_W-1:0] req_correlation,
   input  wire logic [msd_pkg::FEAT_W-1:0]        req_gradient,
   input  wire logic [msd_pkg::TIME_WIDTH-1:0]    req_timestamp,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [msd_pkg::SCORE_W-1:0]     rsp_score,
   output logic [msd_pkg::CONF_W-1:0]             rsp_confidence,
   output logic                                   rsp_detected,
   output logic [msd_pkg::RUN_W-1:0]              rsp_run_count,
   // configuration
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [msd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [msd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import msd_pkg::*;

   // Configuration registers
   logic signed [WEIGHT_W-1:0] w_ff [FEAT_COUNT];
   logic signed [SCORE_W-1:0]  thr_ff;
   logic [RUN_W-1:0]           deb_ff;
   logic [HOLD_W-1:0]          hold_ff;

   // Control and detection state
   state_type               state_ff, state_in;
   logic                    det_ff, det_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic [TIME_WIDTH-1:0]   entry_ff, entry_in;
   logic                    rsp_valid_ff;

   // Item payload and working registers
   logic [VAR_W-1:0]           var_ff;
   logic [FEAT_W-1:0]          ent_ff, spr_ff, grad_ff;
   logic signed [FEAT_W-1:0]   corr_ff;
   logic [TIME_WIDTH-1:0]      ts_ff;
   feat_type                   k_ff;
   logic signed [SCORE_W-1:0]  score_ff;
   logic [CONF_W-1:0]          conf_ff, conf_in;

   // Output registers
   logic signed [SCORE_W-1:0] o_score_ff;
   logic [CONF_W-1:0]         o_conf_ff;
   logic                      o_det_ff;
   logic [RUN_W-1:0]          o_run_ff;

   // Shared unit links
   div_req_type div_req;
   div_rsp_type div_rsp;
   mac_req_type mac_req;
   mac_rsp_type mac_rsp;

   // Feature clamp / normalize
   logic [VAR_W-1:0]          feat_x, feat_lo, feat_hi;
   logic                      clamp_lo, clamp_hi, need_div;
   logic signed [FEAT_W-1:0]  corr_cl;
   logic signed [NORM_W-1:0]  corr_off;
   logic [NORM_W-1:0]         corr_norm, feat_norm;

   // Confidence decision
   logic                      thr_pos, score_pos, need_cdiv;
   logic [CONF_W-1:0]         conf_direct;

   // Debounce update
   logic                      above, expired, out_free, advance;
   logic [RUN_W-1:0]          run_inc;
   logic [TIME_WIDTH-1:0]     elapsed;

   msd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   msd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .rsp   (mac_rsp)
   );

   // Select range of the current feature
   always_comb begin
      feat_x  = '0;
      feat_lo = '0;
      feat_hi = VAR_HI;
      case (k_ff)
         FEAT_VARIANCE: begin
            feat_x  = var_ff;
            feat_hi = VAR_HI;
         end
         FEAT_ENTROPY: begin
            feat_x  = VAR_W'(ent_ff);
            feat_lo = ENT_LO;
            feat_hi = ENT_HI;
         end
         FEAT_SPREAD: begin
            feat_x  = VAR_W'(spr_ff);
            feat_hi = SPREAD_HI;
         end
         FEAT_GRADIENT: begin
            feat_x  = VAR_W'(grad_ff);
            feat_hi = GRAD_HI;
         end
         default: begin
            feat_x = '0;
         end
      endcase
      clamp_lo = feat_x <= feat_lo;
      clamp_hi = feat_x >= feat_hi;
      need_div = (k_ff != FEAT_CORRELATION) && !clamp_lo && !clamp_hi;

      // correlation maps exactly: (c + 1.0) / 2 in Q1.16
      if (corr_ff < -FEAT_W'(CORR_ONE)) begin
         corr_cl = -FEAT_W'(CORR_ONE);
      end else if (corr_ff > FEAT_W'(CORR_ONE)) begin
         corr_cl = FEAT_W'(CORR_ONE);
      end else begin
         corr_cl = corr_ff;
      end
      corr_off  = NORM_W'(corr_cl) + CORR_ONE;
      corr_norm = {corr_off[NORM_W-2:0], 1'b0};

      if (k_ff == FEAT_CORRELATION) begin
         feat_norm = corr_norm;
      end else begin
         feat_norm = clamp_hi ? NORM_ONE : '0;
      end
   end

   // Confidence without division where possible
   always_comb begin
      thr_pos   = (thr_ff > 0);
      score_pos = (score_ff > 0);
      need_cdiv = thr_pos && score_pos && (score_ff < thr_ff);
      if (!thr_pos) begin
         conf_direct = score_pos ? CONF_ONE : '0;
      end else if (score_ff >= thr_ff) begin
         conf_direct = CONF_ONE;
      end else begin
         conf_direct = '0;
      end
   end

   // Debounce and hold
   always_comb begin
      above    = score_ff > thr_ff;
      run_inc  = (run_ff == RUN_MAX) ? RUN_MAX : run_ff + RUN_W'(1);
      elapsed  = (ts_ff >= entry_ff) ? ts_ff - entry_ff : '0;
      expired  = elapsed > TIME_WIDTH'(hold_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
      det_in   = det_ff;
      run_in   = run_ff;
      entry_in = entry_ff;
      conf_in  = conf_ff;
      if (above && !det_ff) begin
         run_in = run_inc;
         if (run_inc >= deb_ff) begin
            det_in   = 1'b1;
            entry_in = ts_ff;
         end
      end else if (!above && det_ff) begin
         if (expired) begin
            det_in  = 1'b0;
            run_in  = '0;
            conf_in = '0;
         end
      end else if (!above && !det_ff) begin
         run_in = '0;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FEAT;
         end
         ST_FEAT: begin
            if (need_div) begin
               state_in = ST_DIV;
            end else if (k_ff == FEAT_GRADIENT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = (k_ff == FEAT_GRADIENT) ? ST_DRAIN : ST_FEAT;
            end
         end
         ST_DRAIN: begin
            if (!mac_rsp.busy) state_in = ST_SCORE;
         end
         ST_SCORE: begin
            state_in = ST_CONF;
         end
         ST_CONF: begin
            state_in = need_cdiv ? ST_CDIV : ST_FINISH;
         end
         ST_CDIV: begin
            if (div_rsp.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      advance   = ((state_ff == ST_FEAT) && !need_div) ||
                  ((state_ff == ST_DIV) && div_rsp.done);

      mac_req.clr     = (state_ff == ST_IDLE) && req_valid;
      mac_req.issue   = advance;
      mac_req.weight  = w_ff[k_ff];
      mac_req.operand = (state_ff == ST_DIV) ? NORM_W'(div_rsp.quo) : feat_norm;

      div_req.start = ((state_ff == ST_FEAT) && need_div) ||
                      ((state_ff == ST_CONF) && need_cdiv);
      if (state_ff == ST_CONF) begin
         div_req.num = DIV_W'(score_ff);
         div_req.den = DIV_W'(thr_ff);
      end else begin
         div_req.num = DIV_W'(feat_x - feat_lo);
         div_req.den = DIV_W'(feat_hi - feat_lo);
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FEAT_COUNT; i++) begin
            w_ff[i] <= '0;
         end
         thr_ff  <= '0;
         deb_ff  <= '0;
         hold_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_WEIGHT_VARIANCE:    w_ff[FEAT_VARIANCE]    <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_ENTROPY:     w_ff[FEAT_ENTROPY]     <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_IQR:         w_ff[FEAT_SPREAD]      <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_CORRELATION: w_ff[FEAT_CORRELATION] <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_GRADIENT:    w_ff[FEAT_GRADIENT]    <= csr_data[WEIGHT_W-1:0];
            CSR_THRESHOLD:          thr_ff  <= csr_data[SCORE_W-1:0];
            CSR_DEBOUNCE_NEEDED:    deb_ff  <= csr_data[RUN_W-1:0];
            CSR_HOLD_TIMEOUT:       hold_ff <= csr_data[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         det_ff       <= 1'b0;
         run_ff       <= '0;
         entry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_FINISH) && out_free) begin
            det_ff       <= det_in;
            run_ff       <= run_in;
            entry_ff     <= entry_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         var_ff  <= req_variance;
         ent_ff  <= req_entropy;
         spr_ff  <= req_spread;
         corr_ff <= req_correlation;
         grad_ff <= req_gradient;
         ts_ff   <= req_timestamp;
         k_ff    <= FEAT_VARIANCE;
      end else if (advance && (k_ff != FEAT_GRADIENT)) begin
         k_ff <= feat_type'(k_ff + 3'd1);
      end
      // accumulator is far below the saturation limits, so the floor shift is exact
      if (state_ff == ST_SCORE) begin
         score_ff <= mac_rsp.acc[ACC_W-1:SCORE_SHIFT];
      end
      if (state_ff == ST_CONF) begin
         conf_ff <= conf_direct;
      end else if ((state_ff == ST_CDIV) && div_rsp.done) begin
         conf_ff <= CONF_W'(div_rsp.quo);
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         o_score_ff <= score_ff;
         o_conf_ff  <= conf_in;
         o_det_ff   <= det_in;
         o_run_ff   <= run_in;
      end
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_score      = o_score_ff;
   assign rsp_confidence = o_conf_ff;
   assign rsp_detected   = o_det_ff;
   assign rsp_run_count  = o_run_ff;

   // Divider results only arrive while the sequencer waits for them
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV || state_ff == ST_CDIV))
      else $error("divider result outside a wait state");

   // A finished item lands in the output register and frees the input
   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not loaded into output register");

   // Detect flag moves only when an item completes
   a_det_only_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FINISH) |=> $stable(det_ff))
      else $error("detect flag changed outside item completion");

   // Entering detection records the item's time
   a_entry_time: assert property (@(posedge clock) disable iff (reset)
      $rose(det_ff) |-> (entry_ff == $past(ts_ff)))
      else $error("entry time not captured on detection");

endmodule

`default_nettype wire
